// ===== hdl/sqt_pkg.sv =====
package sqt_pkg;

	localparam int OP_W      = 3;
	localparam int DATA_W    = 8;
	localparam int VOL_W     = 8;
	localparam int BASE_W    = 34;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W     = DATA_W + 1;
	localparam int DIV_STEPS = BASE_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_DIVIDER = 3'd1;
	localparam logic [OP_W-1:0] OP_CONTROL = 3'd2;
	localparam logic [OP_W-1:0] OP_PAUSE   = 3'd3;
	localparam logic [OP_W-1:0] OP_UNPAUSE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;

	localparam logic [DATA_W-1:0] GATE_BITS    = 8'h06;
	localparam logic [DATA_W-1:0] GATE_ON_CODE = 8'h02;
	localparam logic [VOL_W-1:0]  MID_LEVEL    = 8'd128;
	localparam logic [VOL_W-1:0]  VOL_RESET    = 8'd64;
	localparam logic [BASE_W-1:0] BASE_RESET   = 34'h1_0000_0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic tick;
		logic div_start;
		logic div_step;
		logic div_apply;
		logic ctrl_wr;
		logic pause;
		logic unpause;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_diff;
		logic div_last;
	} sts_t;

endpackage

// ===== hdl/sqt_ctrl.sv =====
module sqt_ctrl import sqt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [OP_W-1:0] operation,
	input  sts_t            sts,
	output cmd_t            cmd
);

	state_t state_q;
	state_t state_next;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && (sts.out_free || (operation != OP_TICK));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (operation == OP_DIVIDER) && sts.div_diff) begin
					state_next = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (sts.div_last) begin
					state_next = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_TICK:    cmd.tick      = 1'b1;
						OP_DIVIDER: cmd.div_start = sts.div_diff;
						OP_CONTROL: cmd.ctrl_wr   = 1'b1;
						OP_PAUSE:   cmd.pause     = 1'b1;
						OP_UNPAUSE: cmd.unpause   = 1'b1;
						default:    cmd           = '0;
					endcase
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_APPLY: begin
				cmd.div_apply = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hdl/sqt_dp.sv =====
module sqt_dp import sqt_pkg::*; #(
	parameter int PHASE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [DATA_W-1:0]    data,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BASE_W-1:0]    cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [VOL_W-1:0]     sample
);

	localparam int CW = (PHASE_WIDTH > BASE_W) ? PHASE_WIDTH : BASE_W;
	localparam logic [CW-1:0] STEP_LIMIT = CW'(1) << (PHASE_WIDTH - 2);
	localparam logic [PHASE_WIDTH-1:0] PHASE_HALF = {1'b1, {(PHASE_WIDTH-1){1'b0}}};

	logic [VOL_W-1:0]       volume_q;
	logic [BASE_W-1:0]      base_step_q;
	logic [PHASE_WIDTH-1:0] phase_q;
	logic [PHASE_WIDTH-2:0] phase_step_q;
	logic                   gate_q;
	logic                   saved_gate_q;
	logic [DATA_W-1:0]      divider_q;
	logic [DATA_W-1:0]      control_q;
	logic [DIV_W-1:0]       divisor_q;
	logic [DIV_W-1:0]       rem_q;
	logic [BASE_W-1:0]      quo_q;
	logic [CNT_W-1:0]       count_q;
	logic [VOL_W-1:0]       sample_q;
	logic                   out_valid_q;

	logic [DIV_W:0]         trial;
	logic                   fits;
	logic [CW-1:0]          quo_ext;
	logic [VOL_W:0]         vol_p1;
	logic [VOL_W-1:0]       low_level;
	logic [VOL_W-1:0]       sample_next;
	logic [DATA_W-1:0]      ctrl_diff;

	assign trial       = {rem_q, quo_q[BASE_W-1]};
	assign fits        = trial >= {1'b0, divisor_q};
	assign quo_ext     = CW'(quo_q);
	assign vol_p1      = {1'b0, volume_q} + (VOL_W+1)'(1);
	assign low_level   = MID_LEVEL - vol_p1[VOL_W:1];
	assign sample_next = low_level + ((gate_q && phase_q[PHASE_WIDTH-1]) ? volume_q : '0);
	assign ctrl_diff   = control_q ^ data;

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.div_diff = data != divider_q;
	assign sts.div_last = count_q == CNT_W'(DIV_STEPS - 1);

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q    <= VOL_RESET;
			base_step_q <= BASE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_VOLUME: volume_q    <= cfg_data[VOL_W-1:0];
				CFG_BASE:   base_step_q <= cfg_data;
				default:    volume_q    <= volume_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			phase_step_q <= '0;
			gate_q       <= 1'b0;
			saved_gate_q <= 1'b0;
			divider_q    <= '0;
			control_q    <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.tick) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_q + PHASE_WIDTH'(phase_step_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.div_start) begin
				divider_q <= data;
				count_q   <= '0;
			end
			if (cmd.div_step) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.div_apply) begin
				if (quo_ext > STEP_LIMIT) begin
					phase_step_q <= '0;
					phase_q      <= PHASE_HALF;
				end else begin
					phase_step_q <= (PHASE_WIDTH-1)'(quo_ext);
				end
			end
			if (cmd.ctrl_wr) begin
				control_q <= data;
				if ((ctrl_diff & GATE_BITS) != '0) begin
					gate_q <= (data & GATE_BITS) == GATE_ON_CODE;
				end
			end
			if (cmd.pause) begin
				saved_gate_q <= gate_q;
				gate_q       <= 1'b0;
			end
			if (cmd.unpause) begin
				gate_q <= saved_gate_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			sample_q <= sample_next;
		end
		if (cmd.div_start) begin
			divisor_q <= {1'b0, data} + DIV_W'(1);
			rem_q     <= '0;
			quo_q     <= base_step_q;
		end else if (cmd.div_step) begin
			rem_q <= fits ? DIV_W'(trial - {1'b0, divisor_q}) : trial[DIV_W-1:0];
			quo_q <= {quo_q[BASE_W-2:0], fits};
		end
	end

endmodule

// ===== hdl/square_tone_generator.sv =====
// Output: a sample tick's sample is registered and shows on the output in the cycle
// after the tick is accepted. Input: ticks, control writes, pause and unpause are taken
// while idle, a tick only when the output has room; a divider write that changes the
// divider runs a load, 34 steps of the bit-serial divider and an apply, with the input
// stalled meanwhile. Reset: arst_n clears phase, step, gate and register copies, volume
// to 64, base step to 2^32; the block is ready as soon as reset is released.
module square_tone_generator import sqt_pkg::*; #(
	parameter int PHASE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      operation,
	input  logic [DATA_W-1:0]    data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [VOL_W-1:0]     sample,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BASE_W-1:0]    cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	sqt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	sqt_dp #(
		.PHASE_WIDTH (PHASE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.data      (data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample)
	);

`ifndef NO_ASSERTIONS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.tick, cmd.div_start, cmd.div_step, cmd.div_apply,
			cmd.ctrl_wr, cmd.pause, cmd.unpause}))
		else $error("more than one datapath command at once");

	a_start_steps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> cmd.div_step)
		else $error("divider start not followed by a step");

	a_last_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && sts.div_last) |=> cmd.div_apply)
		else $error("last divider step not followed by apply");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.div_apply) |-> !in_ready)
		else $error("input taken while divider busy");
`endif

endmodule

// ===== sim/square_tone_generator_checker.sv =====
`timescale 1ns / 100ps

module square_tone_generator_checker import sqt_pkg::*; #(
	parameter int PHASE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [OP_W-1:0]      operation,
	input  logic [DATA_W-1:0]    data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [VOL_W-1:0]     sample,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BASE_W-1:0]    cfg_data,
	output int                   pending,
	output int                   mismatches
);

	localparam longint unsigned STEP_CEILING = 64'd1 << (PHASE_WIDTH - 2);
	localparam logic [PHASE_WIDTH-1:0] HALF_SCALE = {1'b1, {(PHASE_WIDTH - 1){1'b0}}};

	logic [VOL_W-1:0]       volume;
	logic [BASE_W-1:0]      base_step;
	logic [PHASE_WIDTH-1:0] phase;
	logic [PHASE_WIDTH-2:0] phase_step;
	logic                   tone_gate;
	logic                   saved_gate;
	logic [DATA_W-1:0]      divider_copy;
	logic [DATA_W-1:0]      control_copy;
	logic [VOL_W-1:0]       sample_due[$];
	logic [VOL_W-1:0]       expected;
	int                     fault_count = 0;

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		fault_count++;
	endtask

	task automatic tone_update(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] d);
		logic [BASE_W-1:0] quotient;
		logic [VOL_W:0]    level;
		case (op)
			OP_TICK: begin
				level = MID_LEVEL - ((volume + 9'd1) >> 1);
				if (tone_gate && phase[PHASE_WIDTH-1])
					level = level + volume;
				sample_due.push_back(level[VOL_W-1:0]);
				phase = phase + PHASE_WIDTH'(phase_step);
			end
			OP_DIVIDER: begin
				if (d != divider_copy) begin
					divider_copy = d;
					quotient = base_step / (BASE_W'(d) + BASE_W'(1));
					if (quotient > STEP_CEILING) begin
						phase_step = '0;
						phase = HALF_SCALE;
					end else begin
						phase_step = (PHASE_WIDTH-1)'(quotient);
					end
				end
			end
			OP_CONTROL: begin
				if (((control_copy ^ d) & GATE_BITS) != '0)
					tone_gate = ((d & GATE_BITS) == GATE_ON_CODE);
				control_copy = d;
			end
			OP_PAUSE: begin
				saved_gate = tone_gate;
				tone_gate = 1'b0;
			end
			OP_UNPAUSE: begin
				tone_gate = saved_gate;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume = VOL_RESET;
			base_step = BASE_RESET;
			phase = '0;
			phase_step = '0;
			tone_gate = 1'b0;
			saved_gate = 1'b0;
			divider_copy = '0;
			control_copy = '0;
			sample_due.delete();
			pending <= 0;
			mismatches <= fault_count;
		end else begin
			if (out_valid && out_ready) begin
				if (sample_due.size() == 0) begin
					report_mismatch($sformatf("sample %0d with none expected", sample));
				end else begin
					expected = sample_due.pop_front();
					if (sample !== expected)
						report_mismatch($sformatf("sample got %0d expected %0d", sample,
							expected));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_VOLUME: volume = cfg_data[VOL_W-1:0];
					CFG_BASE:   base_step = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				tone_update(operation, data);
			pending <= sample_due.size();
			mismatches <= fault_count;
		end
	end

endmodule

// ===== sim/square_tone_generator_tb.sv =====
`timescale 1ns / 100ps

module square_tone_generator_tb import sqt_pkg::*; ();

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SEGMENTS      = 6;
	localparam int SEGMENT_ITEMS = 125;

	localparam logic [OP_W-1:0]      OP_SPARE_FIRST = OP_UNPAUSE + OP_W'(1);
	localparam logic [OP_W-1:0]      OP_SPARE_LAST  = '1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = '1;
	localparam logic [BASE_W-1:0]    BASE_MAX       = '1;
	localparam logic [BASE_W-1:0]    BASE_MIN       = BASE_W'(1);
	localparam logic [VOL_W-1:0]     VOL_MAX        = '1;
	localparam logic [VOL_W-1:0]     VOL_MIN        = '0;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      operation = OP_TICK;
	logic [DATA_W-1:0]    data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [VOL_W-1:0]     sample;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_VOLUME;
	logic [BASE_W-1:0]    cfg_data = '0;

	int pending;
	int mismatches;
	int send_idle = 0;
	int recv_idle = 0;
	int cycle_count = 0;
	bit stall_request = 1'b0;
	logic receiver_hold = 1'b0;

	square_tone_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.data      (data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	square_tone_generator_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.data       (data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.mismatches (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= !receiver_hold && ($urandom_range(0, 99) >= recv_idle);

	// hold off the output long enough for the block to back up into its input
	initial begin
		wait (stall_request);
		@(posedge clk);
		receiver_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] d);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain_samples();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_random();
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] d;
		int                pick;
		pick = $urandom_range(0, 99);
		d = DATA_W'($urandom);
		if (pick < 55)
			op = OP_TICK;
		else if (pick < 70)
			op = OP_DIVIDER;
		else if (pick < 85)
			op = OP_CONTROL;
		else if (pick < 91)
			op = OP_PAUSE;
		else if (pick < 97)
			op = OP_UNPAUSE;
		else
			op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		// favor audible dividers and the tone-on code
		if (op == OP_DIVIDER && $urandom_range(0, 1))
			d = DATA_W'($urandom_range(0, 15));
		if (op == OP_CONTROL && $urandom_range(0, 1))
			d = (d & ~GATE_BITS) | GATE_ON_CODE;
		send_beat(op, d);
	endtask

	initial begin
		logic [VOL_W-1:0]  vol;
		logic [BASE_W-1:0] base;
		logic [63:0]       wide;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(OP_TICK, 8'h00);
		send_beat(OP_CONTROL, GATE_ON_CODE);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_DIVIDER, 8'd3);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_DIVIDER, 8'd3);
		send_beat(OP_DIVIDER, 8'd1);
		send_beat(OP_TICK, 8'hFF);
		send_beat(OP_DIVIDER, 8'd0);
		send_beat(OP_CONTROL, GATE_BITS);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_CONTROL, 8'hFB);
		send_beat(OP_CONTROL, 8'h03);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_PAUSE, 8'h00);
		send_beat(OP_PAUSE, 8'hFF);
		send_beat(OP_UNPAUSE, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_DIVIDER, 8'hFF);
		send_beat(OP_SPARE_FIRST, 8'hFF);
		send_beat(OP_SPARE_LAST, 8'h55);
		send_beat(OP_SPARE_LAST - OP_W'(1), 8'hAA);
		send_beat(OP_TICK, 8'h00);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_samples();
			repeat (SETTLE_CYCLES) @(posedge clk);
			send_idle = (seg < 2) ? 16 : (seg < 4) ? 84 : 0;
			recv_idle = (seg < 2) ? 84 : (seg < 4) ? 16 : 0;
			wide = {$urandom, $urandom};
			vol = VOL_W'($urandom);
			base = (wide[BASE_W-1:0] == '0) ? BASE_MIN : wide[BASE_W-1:0];
			case (seg)
				0: begin
					vol = VOL_MIN;
					base = BASE_MIN;
				end
				1: begin
					vol = VOL_MAX;
					base = BASE_MAX;
				end
				2: base = BASE_RESET;
				default: ;
			endcase
			write_reg(CFG_VOLUME, vol);
			write_reg(CFG_BASE, base);
			if (seg == SEGMENTS - 1)
				write_reg(CFG_SPARE, BASE_MAX);
			cfg_valid <= 1'b0;
			if (seg == 4)
				stall_request = 1'b1;
			for (int i = 0; i < SEGMENT_ITEMS; i++) begin
				if (seg == 2 && i == SEGMENT_ITEMS / 2)
					drain_samples();
				send_random();
			end
		end

		drain_samples();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
